// ===== sv/fur_pkg.sv =====
// ----------------------------------------------------------------------------
// fur_pkg: shared types and constants of the upload receiver
// Job codes, result kinds, header constants and the CRC-16/XMODEM byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package fur_pkg;

    localparam int LENGTH_BITS_DEFAULT = 20;
    localparam int HDR_LEN             = 8;
    localparam int HDR_COUNT_MAX       = HDR_LEN + 1;
    localparam int ADDR_W              = 20;
    localparam int CAP_W               = 21;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [15:0]      MAGIC_WORD     = 16'hFF01;
    localparam logic [7:0]       REJECT_BYTE    = 8'hFF;
    localparam logic [15:0]      CRC_POLY       = 16'h1021;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 21'd65536;

    // result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CRC   = 2'd2
    } kind_t;

    // work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_ECHO_HDR  = 2'd0,
        JOB_ECHO_REJ  = 2'd1,
        JOB_WRITE     = 2'd2,
        JOB_WRITE_CRC = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [7:0]        data;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       crc;
        logic [63:0]       header;
    } job_t;

    // one byte of CRC-16/XMODEM: poly 0x1021, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fur_if.sv =====
// ----------------------------------------------------------------------------
// fur_if: valid/ready channels of the upload receiver
// Byte channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface fur_byte_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, command, data_byte, packet_end, input ready);
    modport sink   (input valid, command, data_byte, packet_end, output ready);
endinterface

interface fur_result_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [7:0]                 out_byte;
    logic [fur_pkg::ADDR_W-1:0] write_address;
    logic                       last;

    modport source (output valid, kind, out_byte, write_address, last, input ready);
    modport sink   (input valid, kind, out_byte, write_address, last, output ready);
endinterface

`default_nettype wire

// ===== sv/fur_front.sv =====
// ----------------------------------------------------------------------------
// fur_front: byte intake and packet classification
// Holds the protocol state, checks headers, updates the CRC and posts one
// job per byte that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module fur_front #(
    parameter int LENGTH_BITS = fur_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    fur_byte_if.sink                       rx,
    input  wire logic                      cfg_we,
    input  wire logic [fur_pkg::CAP_W-1:0] cfg_wdata,
    input  wire logic                      queue_full,
    output fur_pkg::job_t                  job,
    output logic                           job_push
);

    localparam int LEN_W = (LENGTH_BITS < fur_pkg::CAP_W) ? LENGTH_BITS + 1
                                                           : fur_pkg::CAP_W;
    localparam logic [32:0] HARD_LIMIT = 33'd1 << LENGTH_BITS;

    logic [fur_pkg::CAP_W-1:0] capacity_reg;
    logic                      receiving_reg, receiving_next;
    logic                      save_pending_reg, save_pending_next;
    logic                      drop_rest_reg, drop_rest_next;
    logic [3:0]                hdr_count_reg, hdr_count_next;
    logic [LEN_W-1:0]          length_reg, length_next;
    logic [LEN_W-1:0]          offset_reg, offset_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                hdr_reg [fur_pkg::HDR_LEN];

    logic             accept;
    logic             hdr_we;
    logic [15:0]      crc_new;
    logic [LEN_W-1:0] offset_inc;
    logic             last_payload;
    logic [31:0]      len_field;
    logic             len_ok;
    logic             magic_ok;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && !queue_full;

    // decode the header held so far
    assign crc_new      = fur_pkg::crc16_update(crc_reg, rx.data_byte);
    assign offset_inc   = offset_reg + 1'b1;
    assign last_payload = (offset_inc == length_reg);
    assign len_field    = {hdr_reg[2], hdr_reg[3], hdr_reg[4], hdr_reg[5]};
    assign magic_ok     = ({hdr_reg[0], hdr_reg[1]} == fur_pkg::MAGIC_WORD);
    assign len_ok       = (len_field != 32'd0)
                       && (len_field <= 32'(capacity_reg))
                       && (33'(len_field) <= HARD_LIMIT);
    assign hdr_we       = accept && !rx.command && !drop_rest_reg && !receiving_reg
                       && (hdr_count_reg < 4'(fur_pkg::HDR_LEN));

    // classify the accepted transaction
    always_comb
    begin
        receiving_next    = receiving_reg;
        save_pending_next = save_pending_reg;
        drop_rest_next    = drop_rest_reg;
        hdr_count_next    = hdr_count_reg;
        length_next       = length_reg;
        offset_next       = offset_reg;
        crc_next          = crc_reg;
        job_push          = 1'b0;
        job.kind          = fur_pkg::JOB_WRITE;
        job.data          = rx.data_byte;
        job.addr          = fur_pkg::ADDR_W'(offset_reg);
        job.crc           = crc_new;
        job.header        = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3],
                             hdr_reg[4], hdr_reg[5], hdr_reg[6], rx.data_byte};
        if (accept)
        begin
            priority if (rx.command)
            begin
                save_pending_next = 1'b0;
            end
            else if (drop_rest_reg)
            begin
                if (rx.packet_end)
                    drop_rest_next = 1'b0;
            end
            else if (receiving_reg)
            begin
                job_push    = 1'b1;
                offset_next = offset_inc;
                crc_next    = crc_new;
                if (last_payload)
                begin
                    job.kind          = fur_pkg::JOB_WRITE_CRC;
                    save_pending_next = 1'b1;
                    receiving_next    = 1'b0;
                    hdr_count_next    = 4'd0;
                    drop_rest_next    = !rx.packet_end;
                end
            end
            else
            begin
                if (hdr_count_reg < 4'(fur_pkg::HDR_COUNT_MAX))
                    hdr_count_next = hdr_count_reg + 4'd1;
                if (rx.packet_end)
                begin
                    hdr_count_next = 4'd0;
                    if ((hdr_count_reg == 4'(fur_pkg::HDR_LEN - 1)) && !save_pending_reg
                        && magic_ok)
                    begin
                        job_push = 1'b1;
                        if (len_ok)
                        begin
                            job.kind       = fur_pkg::JOB_ECHO_HDR;
                            length_next    = LEN_W'(len_field);
                            offset_next    = '0;
                            crc_next       = 16'h0000;
                            receiving_next = 1'b1;
                        end
                        else
                        begin
                            job.kind = fur_pkg::JOB_ECHO_REJ;
                        end
                    end
                end
            end
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= fur_pkg::CAPACITY_RESET;
            receiving_reg    <= 1'b0;
            save_pending_reg <= 1'b0;
            drop_rest_reg    <= 1'b0;
            hdr_count_reg    <= 4'd0;
            length_reg       <= '0;
            offset_reg       <= '0;
            crc_reg          <= 16'h0000;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            receiving_reg    <= receiving_next;
            save_pending_reg <= save_pending_next;
            drop_rest_reg    <= drop_rest_next;
            hdr_count_reg    <= hdr_count_next;
            length_reg       <= length_next;
            offset_reg       <= offset_next;
            crc_reg          <= crc_next;
        end
    end

    // store header bytes as they arrive
    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_reg[hdr_count_reg[2:0]] <= rx.data_byte;
    end

`ifndef SYNTHESIS
    a_no_drop_while_receiving: assert property (@(posedge clk) disable iff (!rst_n)
        !(receiving_reg && drop_rest_reg))
        else $error("drop and receive active together");

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (offset_reg < length_reg))
        else $error("payload offset beyond length");

    a_end_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && (job.kind == fur_pkg::JOB_WRITE_CRC)) |=>
        (save_pending_reg && !receiving_reg))
        else $error("last payload byte did not close the upload");
`endif

endmodule

`default_nettype wire

// ===== sv/fur_queue.sv =====
// ----------------------------------------------------------------------------
// fur_queue: job queue between front and back
// Small register queue; the front stalls only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fur_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  fur_pkg::job_t       push_job,
    input  wire logic           pop,
    output fur_pkg::job_t       head_job,
    output logic                head_valid,
    output logic                full
);

    localparam int PTR_W = $clog2(fur_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(fur_pkg::QUEUE_DEPTH + 1);

    fur_pkg::job_t    slot_reg [fur_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_job   = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(fur_pkg::QUEUE_DEPTH));

    // advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // write the slot at the tail
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ===== sv/fur_back.sv =====
// ----------------------------------------------------------------------------
// fur_back: result sequencer
// Expands each job into its result transactions through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fur_back (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  fur_pkg::job_t job,
    input  wire logic     job_valid,
    output logic          job_pop,
    fur_result_if.source  tx
);

    logic [2:0]                 step_reg, step_next;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 kind_reg;
    logic [7:0]                 byte_reg;
    logic [fur_pkg::ADDR_W-1:0] addr_reg;
    logic                       last_reg;

    logic                       load;
    logic [2:0]                 hdr_idx;
    fur_pkg::kind_t             res_kind;
    logic [7:0]                 res_byte;
    logic [fur_pkg::ADDR_W-1:0] res_addr;
    logic                       res_last;

    assign load    = job_valid && (!out_valid_reg || tx.ready);
    assign hdr_idx = ~step_reg;
    assign job_pop = load && res_last;

    // form the result for the current step of the head job
    always_comb
    begin
        res_kind = fur_pkg::KIND_ECHO;
        res_byte = job.header[{hdr_idx, 3'b000} +: 8];
        res_addr = '0;
        res_last = (step_reg == 3'(fur_pkg::HDR_LEN - 1));
        unique case (job.kind)
            fur_pkg::JOB_ECHO_HDR:
            begin
                res_kind = fur_pkg::KIND_ECHO;
            end
            fur_pkg::JOB_ECHO_REJ:
            begin
                res_byte = fur_pkg::REJECT_BYTE;
            end
            fur_pkg::JOB_WRITE:
            begin
                res_kind = fur_pkg::KIND_WRITE;
                res_byte = job.data;
                res_addr = job.addr;
                res_last = 1'b1;
            end
            fur_pkg::JOB_WRITE_CRC:
            begin
                res_last = (step_reg == 3'd2);
                if (step_reg == 3'd0)
                begin
                    res_kind = fur_pkg::KIND_WRITE;
                    res_byte = job.data;
                    res_addr = job.addr;
                end
                else
                begin
                    res_kind = fur_pkg::KIND_CRC;
                    res_byte = (step_reg == 3'd1) ? job.crc[15:8] : job.crc[7:0];
                end
            end
        endcase
    end

    // advance step and output valid
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = res_last ? 3'd0 : step_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res_kind;
            byte_reg <= res_byte;
            addr_reg <= res_addr;
            last_reg <= res_last;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.kind          = kind_reg;
    assign tx.out_byte      = byte_reg;
    assign tx.write_address = addr_reg;
    assign tx.last          = last_reg;

endmodule

`default_nettype wire

// ===== sv/framed_upload_receiver_crc16_top.sv =====
// ----------------------------------------------------------------------------
// framed_upload_receiver_crc16_top: framed upload receiver with CRC-16
// Header check and echo, payload writes with offsets, CRC-16/XMODEM trailer.
//
//   channel      dir   handshake      payload
//   byte_chan    in    valid/ready    command, data_byte, packet_end
//   result_chan  out   valid/ready    kind, out_byte, write_address, last
//   cfg          in    cfg_we         cfg_wdata (payload capacity)
//
// A byte transaction is taken every cycle while the four-entry job queue has
// room. Payload bytes give one result per cycle; a header gives eight results
// and the last payload byte three, set by the one-result-per-cycle output
// register of the back end. A stalled result channel fills the queue and then
// stalls byte_chan. Reset clears control state at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_upload_receiver_crc16_top #(
    parameter int LENGTH_BITS = fur_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    fur_byte_if.sink                       byte_chan,
    fur_result_if.source                   result_chan,
    input  wire logic                      cfg_we,
    input  wire logic [fur_pkg::CAP_W-1:0] cfg_wdata
);

    fur_pkg::job_t push_job;
    fur_pkg::job_t head_job;
    logic          push;
    logic          pop;
    logic          head_valid;
    logic          full;

    // classify incoming bytes
    fur_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (byte_chan),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .queue_full (full),
        .job        (push_job),
        .job_push   (push)
    );

    // decouple front and back
    fur_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .full       (full)
    );

    // emit result transactions
    fur_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_valid (head_valid),
        .job_pop   (pop),
        .tx        (result_chan)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the framed upload receiver
// Drives request headers, payloads, save-finished commands and malformed
// packets into the byte channel, predicts every echo, payload write and CRC
// byte in a scoreboard, and checks the result channel in order. The sender
// runs in bursts with gaps, the receiver stalls on its own pattern, and the
// payload capacity is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 90;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 55;
    localparam int PHASE_COUNT   = 6;
    localparam int FRAME_MAX     = 12;

    // one expected transaction on the result channel
    typedef struct packed {
        fur_pkg::kind_t            kind;
        logic [7:0]                out_byte;
        logic [fur_pkg::ADDR_W-1:0] write_address;
        logic                      last;
    } upload_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the receiver state and holds the awaited results
    // ------------------------------------------------------------------------
    class upload_scoreboard;
        logic [fur_pkg::CAP_W-1:0] capacity;
        bit                        receiving;
        bit                        save_pending;
        bit                        drop_rest;
        logic [7:0]                header [fur_pkg::HDR_LEN];
        int unsigned               header_count;
        logic [31:0]               payload_length;
        logic [31:0]               byte_offset;
        logic [15:0]               crc;
        upload_result_t            awaited_results [$];
        int unsigned               mismatch_count;

        function new();
            capacity       = fur_pkg::CAPACITY_RESET;
            receiving      = 1'b0;
            save_pending   = 1'b0;
            drop_rest      = 1'b0;
            header_count   = 0;
            payload_length = '0;
            byte_offset    = '0;
            crc            = '0;
            mismatch_count = 0;
            foreach (header[i])
                header[i] = '0;
        endfunction

        // shift one byte into CRC-16/XMODEM, msb first
        function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic feedback;
            for (int i = 7; i >= 0; i--)
            begin
                feedback = c[15] ^ b[i];
                c = {c[14:0], 1'b0} ^ (feedback ? fur_pkg::CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        function void await_result(fur_pkg::kind_t k, logic [7:0] b,
                                   logic [fur_pkg::ADDR_W-1:0] a, bit l);
            upload_result_t r;
            r.kind          = k;
            r.out_byte      = b;
            r.write_address = a;
            r.last          = l;
            awaited_results.push_back(r);
        endfunction

        // advance the state by one accepted byte transaction
        function void predict_byte(bit command, logic [7:0] data, bit packet_end);
            logic [31:0] length_field;
            logic [31:0] limit;
            bit          done;
            if (command)
            begin
                save_pending = 1'b0;
                return;
            end
            if (drop_rest)
            begin
                if (packet_end)
                    drop_rest = 1'b0;
                return;
            end
            // payload byte: write it, close with the CRC after the last one
            if (receiving)
            begin
                done = (byte_offset + 1 >= payload_length);
                await_result(fur_pkg::KIND_WRITE, data,
                             byte_offset[fur_pkg::ADDR_W-1:0], !done);
                crc         = crc_next(crc, data);
                byte_offset = byte_offset + 1;
                if (done)
                begin
                    await_result(fur_pkg::KIND_CRC, crc[15:8], '0, 1'b0);
                    await_result(fur_pkg::KIND_CRC, crc[7:0], '0, 1'b1);
                    save_pending = 1'b1;
                    receiving    = 1'b0;
                    header_count = 0;
                    if (!packet_end)
                        drop_rest = 1'b1;
                end
                return;
            end
            // idle: collect the packet, saturating past the header length
            if (header_count < fur_pkg::HDR_LEN)
                header[header_count] = data;
            if (header_count < fur_pkg::HDR_COUNT_MAX)
                header_count++;
            if (!packet_end)
                return;
            if (header_count == fur_pkg::HDR_LEN && !save_pending &&
                {header[0], header[1]} == fur_pkg::MAGIC_WORD)
            begin
                length_field = {header[2], header[3], header[4], header[5]};
                limit = (1 << fur_pkg::LENGTH_BITS_DEFAULT);
                if (capacity < limit)
                    limit = capacity;
                if (length_field != 0 && length_field <= limit)
                begin
                    for (int i = 0; i < fur_pkg::HDR_LEN; i++)
                        await_result(fur_pkg::KIND_ECHO, header[i], '0,
                                     i == fur_pkg::HDR_LEN - 1);
                    payload_length = length_field;
                    byte_offset    = '0;
                    crc            = '0;
                    receiving      = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < fur_pkg::HDR_LEN; i++)
                        await_result(fur_pkg::KIND_ECHO, fur_pkg::REJECT_BYTE, '0,
                                     i == fur_pkg::HDR_LEN - 1);
                end
            end
            header_count = 0;
        endfunction

        // compare one result transaction with the oldest awaited one
        function void check_result(logic [1:0] k, logic [7:0] b,
                                   logic [fur_pkg::ADDR_W-1:0] a, logic l);
            upload_result_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: kind %0d byte %h address %h last %b",
                         $time, k, b, a, l);
                mismatch_count++;
                return;
            end
            want = awaited_results.pop_front();
            if (k !== want.kind)
            begin
                $display("%0t: kind: expected %0d actual %0d", $time, want.kind, k);
                mismatch_count++;
            end
            if (b !== want.out_byte)
            begin
                $display("%0t: out_byte: expected %h actual %h", $time, want.out_byte, b);
                mismatch_count++;
            end
            if (a !== want.write_address)
            begin
                $display("%0t: write_address: expected %h actual %h",
                         $time, want.write_address, a);
                mismatch_count++;
            end
            if (l !== want.last)
            begin
                $display("%0t: last: expected %b actual %b", $time, want.last, l);
                mismatch_count++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [fur_pkg::CAP_W-1:0] cfg_wdata;

    fur_byte_if   byte_chan ();
    fur_result_if result_chan ();

    framed_upload_receiver_crc16_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    upload_scoreboard sb = new();

    int unsigned               burst_left;
    bit                        steady;
    bit                        pend_save;
    bit                        stall_results_req;
    int unsigned               counted;
    int unsigned               quiet_cycles;
    logic [fur_pkg::CAP_W-1:0] cur_capacity;

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: score both channels and watch for a stuck block
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (result_chan.valid === 1'b1 && result_chan.ready === 1'b1)
                sb.check_result(result_chan.kind, result_chan.out_byte,
                                result_chan.write_address, result_chan.last);
            if (byte_chan.valid === 1'b1 && byte_chan.ready === 1'b1)
                sb.predict_byte(byte_chan.command, byte_chan.data_byte,
                                byte_chan.packet_end);
            if ((result_chan.valid === 1'b1 && result_chan.ready === 1'b1) ||
                (byte_chan.valid === 1'b1 && byte_chan.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: stall in segments, hold off long on request
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned span;
        int unsigned mode;
        result_chan.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            span = $urandom_range(1, 40);
            mode = $urandom_range(0, 2);
            repeat (span)
            begin
                if (stall_results_req)
                begin
                    stall_results_req = 1'b0;
                    result_chan.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       result_chan.ready <= 1'b1;
                    1:       result_chan.ready <= 1'($urandom_range(0, 1));
                    default: result_chan.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // offer one byte transaction, hold until taken, then maybe idle
    task automatic send_byte(input bit cmd, input logic [7:0] data, input bit pend);
        int unsigned gap;
        byte_chan.valid      <= 1'b1;
        byte_chan.command    <= cmd;
        byte_chan.data_byte  <= data;
        byte_chan.packet_end <= pend;
        do @(posedge clk); while (byte_chan.ready !== 1'b1);
        counted++;
        if (cmd)
            pend_save = 1'b0;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 10);
                byte_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_save_done();
        send_byte(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // send a header-shaped packet of nbytes, ending it on the last byte
    task automatic send_header(input logic [15:0] magic, input logic [31:0] length,
                               input int unsigned nbytes);
        logic [7:0] frame [FRAME_MAX];
        frame[0] = magic[15:8];
        frame[1] = magic[7:0];
        frame[2] = length[31:24];
        frame[3] = length[23:16];
        frame[4] = length[15:8];
        frame[5] = length[7:0];
        for (int i = 6; i < FRAME_MAX; i++)
            frame[i] = 8'($urandom);
        for (int i = 0; i < nbytes; i++)
            send_byte(1'b0, frame[i], i == nbytes - 1);
    endtask

    // send n payload bytes, then the surplus of the packet if it goes on
    task automatic send_payload(input int unsigned n);
        bit          end_last;
        int unsigned extra;
        end_last = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++)
            send_byte(1'b0, 8'($urandom),
                      (i == n - 1) ? end_last : 1'($urandom_range(0, 1)));
        pend_save = 1'b1;
        if (!end_last)
        begin
            extra = $urandom_range(0, 3);
            repeat (extra)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_save_done();
                else
                    send_byte(1'b0, 8'($urandom), 1'b0);
            end
            send_byte(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    function automatic int unsigned length_limit();
        int unsigned hard;
        hard = 1 << fur_pkg::LENGTH_BITS_DEFAULT;
        return (cur_capacity < hard) ? cur_capacity : hard;
    endfunction

    // one request header, accepted, refused or ignored while a save is pending, with its payload if taken
    task automatic run_upload();
        int unsigned limit;
        logic [31:0] length;
        bit          take;
        if (pend_save && $urandom_range(0, 4) != 0)
            send_save_done();
        limit = length_limit();
        take  = ($urandom_range(0, 3) != 0);
        if (take)
        begin
            length = $urandom_range(1, (limit < 24) ? limit : 24);
            if (limit <= 64 && $urandom_range(0, 9) == 0)
                length = limit;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       length = 32'd0;
                1:       length = limit + 1;
                2:       length = 32'hFFFF_FFFF;
                default: length = $urandom | 32'h0020_0000;
            endcase
        end
        send_header(fur_pkg::MAGIC_WORD, length, fur_pkg::HDR_LEN);
        if (take && !pend_save)
            send_payload(length);
    endtask

    // malformed or ignored packets in idle
    task automatic run_noise();
        int unsigned n;
        case ($urandom_range(0, 4))
            0: send_header(fur_pkg::MAGIC_WORD, 32'd1,
                           $urandom_range(1, fur_pkg::HDR_LEN - 1));
            1: send_header(fur_pkg::MAGIC_WORD, 32'd1,
                           $urandom_range(fur_pkg::HDR_LEN + 1, FRAME_MAX));
            2: send_header(fur_pkg::MAGIC_WORD ^ (16'h0001 << $urandom_range(0, 15)),
                           $urandom_range(1, 8), fur_pkg::HDR_LEN);
            3:
            begin
                n = $urandom_range(1, 10);
                send_byte(1'b0, 8'($urandom_range(0, 254)), n == 1);
                for (int i = 1; i < n; i++)
                    send_byte(1'b0, 8'($urandom), i == n - 1);
            end
            default: send_save_done();
        endcase
    endtask

    // stop offering and wait out every awaited result
    task automatic drain_results();
        byte_chan.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [fur_pkg::CAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.capacity  = value;
        cur_capacity = value;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [fur_pkg::CAP_W-1:0] next_capacity;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        byte_chan.valid      <= 1'b0;
        byte_chan.command    <= 1'b0;
        byte_chan.data_byte  <= '0;
        byte_chan.packet_end <= 1'b0;
        burst_left        = 0;
        steady            = 1'b0;
        pend_save         = 1'b0;
        stall_results_req = 1'b0;
        counted           = 0;
        quiet_cycles      = 0;
        cur_capacity      = fur_pkg::CAPACITY_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: save done in idle, smallest upload with trailing surplus,
        // header while a save is pending, all-ones length refused
        send_byte(1'b1, 8'hA5, 1'b1);
        send_header(fur_pkg::MAGIC_WORD, 32'd1, fur_pkg::HDR_LEN);
        send_byte(1'b0, 8'hFF, 1'b0);
        pend_save = 1'b1;
        send_byte(1'b0, 8'h00, 1'b1);
        send_header(fur_pkg::MAGIC_WORD, 32'd1, fur_pkg::HDR_LEN);
        send_byte(1'b1, 8'h5A, 1'b0);
        send_header(fur_pkg::MAGIC_WORD, 32'hFFFF_FFFF, fur_pkg::HDR_LEN);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase != 0)
            begin
                drain_results();
                case (phase)
                    1:       next_capacity = 21'd1;
                    2:       next_capacity = 21'd1048576;
                    3:       next_capacity = 21'd9;
                    4:       next_capacity = fur_pkg::CAP_W'($urandom_range(2, 40));
                    default: next_capacity = fur_pkg::CAPACITY_RESET;
                endcase
                write_capacity(next_capacity);
            end

            // back-pressure: stall results while the sender streams a payload
            if (phase == 2)
            begin
                if (pend_save)
                    send_save_done();
                stall_results_req = 1'b1;
                steady = 1'b1;
                send_header(fur_pkg::MAGIC_WORD, 32'd40, fur_pkg::HDR_LEN);
                send_payload(40);
                steady = 1'b0;
                drain_results();
            end

            // one longer upload
            if (phase == 5)
            begin
                if (pend_save)
                    send_save_done();
                send_header(fur_pkg::MAGIC_WORD, 32'd64, fur_pkg::HDR_LEN);
                send_payload(64);
            end

            while (counted < (phase + 1) * PHASE_ITEMS)
            begin
                steady = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 99) < 65)
                    run_upload();
                else
                    run_noise();
            end
            steady = 1'b0;
        end

        drain_results();
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0t: %0d mismatches, %0d results never came",
                     $time, sb.mismatch_count, sb.outstanding());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
